FILE: design/uart_rx_idle_timeout_framer_unit_assert.svh
// ----------------------------------------------------------------------------
// uart_rx_idle_timeout_framer_unit assertion macros
// Concurrent assertion wrappers on clk with synchronous active-low rst_n.
// ----------------------------------------------------------------------------
`ifndef UART_RX_IDLE_TIMEOUT_FRAMER_UNIT_ASSERT_SVH
`define UART_RX_IDLE_TIMEOUT_FRAMER_UNIT_ASSERT_SVH

`ifndef SYNTHESIS

// antecedent implies consequent in the same cycle
`define URX_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// antecedent implies consequent in the next cycle
`define URX_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`else

`define URX_ASSERT_IMP(lbl, ante, cons, msg)
`define URX_ASSERT_NXT(lbl, ante, cons, msg)

`endif

`endif

FILE: design/urx_ito_pkg.sv
// ----------------------------------------------------------------------------
// urx_ito_pkg
// Shared types and constants of the UART receive idle-timeout framer.
// ----------------------------------------------------------------------------
package urx_ito_pkg;

  localparam int BYTE_W        = 8;
  localparam int FILL_W        = 7;
  localparam int TMO_W         = 16;
  localparam int CFG_IDX_W     = 1;
  localparam int CFG_DATA_W    = 16;
  localparam int DEF_BUF_DEPTH = 64;

  localparam logic [TMO_W-1:0] TMO_RESET = 16'd10;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SINGLE_BYTE_MODE = 1'b0,
    REG_FRAME_TIMEOUT    = 1'b1
  } cfg_reg_t;

  typedef enum logic {
    REQ_BYTE = 1'b0,
    REQ_TICK = 1'b1
  } req_kind_t;

  typedef enum logic {
    CMD_SINGLE = 1'b0,
    CMD_DRAIN  = 1'b1
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t         kind;
    logic [BYTE_W-1:0] data;
    logic [FILL_W-1:0] cnt;
    logic              drop;
  } cmd_t;

endpackage

FILE: design/uart_rx_idle_timeout_framer_unit.sv
// ----------------------------------------------------------------------------
// uart_rx_idle_timeout_framer_unit
// Receive-side frame assembler that closes a frame after an idle timeout.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_ready): each request is a received byte
// (in_req_type = 0) or a 1 ms tick (in_req_type = 1). Output channel
// (out_valid/out_ready): frame bytes with last and overflow marks.
// cfg_wr_en/cfg_index/cfg_wr_data write single_byte_mode (0) and
// frame_timeout (1); the user writes them only while the block is idle, not enforced by the block.
// Requests are taken one per cycle while no frame drains and the two-entry
// command queue has room. In single-byte mode a taken byte is queued and
// then loaded into the output register once that is free. A timeout tick
// starts a drain: the frame store is read one byte at a time (registered
// RAM read while the output register is free, then the output register),
// and intake stays closed until the last byte of the frame is loaded.
// Reset clears the fill count, idle timer, queue, drain state and output
// valid flag and restores the register defaults, but not the frame store.
// A stalled receiver holds the output register: a drain waits, and in
// single-byte mode the queue fills, after which intake closes.
// ----------------------------------------------------------------------------
module uart_rx_idle_timeout_framer_unit import urx_ito_pkg::*; #(
  parameter int BUF_DEPTH = DEF_BUF_DEPTH
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wr_data,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  in_req_type,
  input  logic [BYTE_W-1:0]     in_rx_byte,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [BYTE_W-1:0]     out_frame_byte,
  output logic                  out_frame_last,
  output logic                  out_frame_overflow
);

  localparam int AW = (BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1;

  logic              ram_wr_en;
  logic [AW-1:0]     ram_wr_addr;
  logic [BYTE_W-1:0] ram_wr_data;
  logic              ram_rd_en;
  logic [AW-1:0]     ram_rd_addr;
  logic [BYTE_W-1:0] ram_rd_data;
  logic              q_push;
  cmd_t              q_push_cmd;
  logic              q_pop;
  cmd_t              q_head_cmd;
  logic              q_empty;
  logic              q_full;
  logic              drain_done;

  urx_ito_front #(
    .BUF_DEPTH (BUF_DEPTH),
    .AW        (AW)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_index   (cfg_index),
    .cfg_wr_data (cfg_wr_data),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_req_type (in_req_type),
    .in_rx_byte  (in_rx_byte),
    .ram_wr_en   (ram_wr_en),
    .ram_wr_addr (ram_wr_addr),
    .ram_wr_data (ram_wr_data),
    .q_push      (q_push),
    .q_cmd       (q_push_cmd),
    .q_full      (q_full),
    .drain_done  (drain_done)
  );

  urx_ito_cmdq u_cmdq (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (q_push_cmd),
    .pop      (q_pop),
    .head_cmd (q_head_cmd),
    .empty    (q_empty),
    .full     (q_full)
  );

  urx_ito_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (BUF_DEPTH),
    .AW    (AW)
  ) u_frame_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  urx_ito_back #(
    .BUF_DEPTH (BUF_DEPTH),
    .AW        (AW)
  ) u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .q_cmd              (q_head_cmd),
    .q_empty            (q_empty),
    .q_pop              (q_pop),
    .ram_rd_en          (ram_rd_en),
    .ram_rd_addr        (ram_rd_addr),
    .ram_rd_data        (ram_rd_data),
    .drain_done         (drain_done),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_frame_byte     (out_frame_byte),
    .out_frame_last     (out_frame_last),
    .out_frame_overflow (out_frame_overflow)
  );

endmodule

FILE: design/urx_ito_ram.sv
// ----------------------------------------------------------------------------
// urx_ito_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module urx_ito_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

FILE: design/urx_ito_cmdq.sv
// ----------------------------------------------------------------------------
// urx_ito_cmdq
// Two-entry command queue between the front and back parts.
// ----------------------------------------------------------------------------
module urx_ito_cmdq import urx_ito_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t push_cmd,
  input  logic pop,
  output cmd_t head_cmd,
  output logic empty,
  output logic full
);

  cmd_t       mem_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       do_push, do_pop;

  assign empty    = (cnt_r == 2'd0);
  assign full     = (cnt_r == 2'd2);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign head_cmd = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r ^ do_push;
    rd_ptr_nxt = rd_ptr_r ^ do_pop;
    cnt_nxt    = cnt_r + 2'(do_push) - 2'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

FILE: design/urx_ito_front.sv
// ----------------------------------------------------------------------------
// urx_ito_front
// Request intake: configuration, frame store writes, idle timer, commands.
// ----------------------------------------------------------------------------
`include "uart_rx_idle_timeout_framer_unit_assert.svh"

module urx_ito_front import urx_ito_pkg::*; #(
  parameter int BUF_DEPTH = DEF_BUF_DEPTH,
  parameter int AW        = (BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wr_data,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  in_req_type,
  input  logic [BYTE_W-1:0]     in_rx_byte,
  output logic                  ram_wr_en,
  output logic [AW-1:0]         ram_wr_addr,
  output logic [BYTE_W-1:0]     ram_wr_data,
  output logic                  q_push,
  output cmd_t                  q_cmd,
  input  logic                  q_full,
  input  logic                  drain_done
);

  logic              mode_r;
  logic [TMO_W-1:0]  tmo_r;
  logic [FILL_W-1:0] fill_r, fill_nxt;
  logic [TMO_W-1:0]  idle_r, idle_nxt;
  logic              armed_r, armed_nxt;
  logic              drop_r, drop_nxt;
  logic              busy_r, busy_nxt;
  logic              fire;
  logic [TMO_W-1:0]  idle_inc;

  assign in_ready = !busy_r && !q_full;
  assign fire     = in_valid && in_ready;
  assign idle_inc = idle_r + TMO_W'(1);

  always_comb begin
    fill_nxt    = fill_r;
    idle_nxt    = idle_r;
    armed_nxt   = armed_r;
    drop_nxt    = drop_r;
    busy_nxt    = busy_r && !drain_done;
    ram_wr_en   = 1'b0;
    ram_wr_addr = fill_r[AW-1:0];
    ram_wr_data = in_rx_byte;
    q_push      = 1'b0;
    q_cmd.kind  = CMD_SINGLE;
    q_cmd.data  = in_rx_byte;
    q_cmd.cnt   = fill_r;
    q_cmd.drop  = drop_r;
    if (fire) begin
      if (in_req_type == REQ_BYTE) begin
        if (mode_r) begin
          q_push = 1'b1;
        end else begin
          if (fill_r < FILL_W'(BUF_DEPTH)) begin
            ram_wr_en = 1'b1;
            fill_nxt  = fill_r + FILL_W'(1);
          end else begin
            drop_nxt = 1'b1;
          end
          idle_nxt  = '0;
          armed_nxt = 1'b1;
        end
      end else if (armed_r) begin
        if (idle_inc == tmo_r) begin
          // end of frame: hand the buffered bytes to the back part
          if (fill_r != '0) begin
            q_push     = 1'b1;
            q_cmd.kind = CMD_DRAIN;
            busy_nxt   = 1'b1;
          end
          fill_nxt  = '0;
          idle_nxt  = '0;
          armed_nxt = 1'b0;
          drop_nxt  = 1'b0;
        end else begin
          idle_nxt = idle_inc;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= 1'b0;
      tmo_r   <= TMO_RESET;
      fill_r  <= '0;
      idle_r  <= '0;
      armed_r <= 1'b0;
      drop_r  <= 1'b0;
      busy_r  <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        case (cfg_reg_t'(cfg_index))
          REG_SINGLE_BYTE_MODE: mode_r <= cfg_wr_data[0];
          REG_FRAME_TIMEOUT:    tmo_r  <= cfg_wr_data[TMO_W-1:0];
          default: ;
        endcase
      end
      fill_r  <= fill_nxt;
      idle_r  <= idle_nxt;
      armed_r <= armed_nxt;
      drop_r  <= drop_nxt;
      busy_r  <= busy_nxt;
    end
  end

  `URX_ASSERT_IMP(a_busy_blocks_intake, busy_r, !in_ready, "intake open during drain")
  `URX_ASSERT_IMP(a_fill_bound, 1'b1, fill_r <= FILL_W'(BUF_DEPTH), "fill count past depth")
  `URX_ASSERT_IMP(a_idle_disarmed, !armed_r, idle_r == '0, "idle count runs while disarmed")
  `URX_ASSERT_IMP(a_drain_nonempty, q_push && q_cmd.kind == CMD_DRAIN, q_cmd.cnt != '0,
                  "drain of an empty frame")
  `URX_ASSERT_NXT(a_drain_sets_busy, q_push && q_cmd.kind == CMD_DRAIN, busy_r,
                  "drain issued without busy")

endmodule

FILE: design/urx_ito_back.sv
// ----------------------------------------------------------------------------
// urx_ito_back
// Command execution: single-byte pass-through and frame drain to the output.
// ----------------------------------------------------------------------------
module urx_ito_back import urx_ito_pkg::*; #(
  parameter int BUF_DEPTH = DEF_BUF_DEPTH,
  parameter int AW        = (BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1
) (
  input  logic              clk,
  input  logic              rst_n,
  input  cmd_t              q_cmd,
  input  logic              q_empty,
  output logic              q_pop,
  output logic              ram_rd_en,
  output logic [AW-1:0]     ram_rd_addr,
  input  logic [BYTE_W-1:0] ram_rd_data,
  output logic              drain_done,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [BYTE_W-1:0] out_frame_byte,
  output logic              out_frame_last,
  output logic              out_frame_overflow
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_READ = 3'b010,
    ST_LOAD = 3'b100
  } back_state_t;

  back_state_t       state_r, state_nxt;
  logic [FILL_W-1:0] cnt_r, cnt_nxt;
  logic [FILL_W-1:0] idx_r, idx_nxt;
  logic              drop_r, drop_nxt;
  logic              vld_r, vld_nxt;
  logic [BYTE_W-1:0] byte_r, byte_nxt;
  logic              last_r, last_nxt;
  logic              ovf_r, ovf_nxt;
  logic              slot_free;
  logic              is_last;

  assign slot_free   = !vld_r || out_ready;
  assign is_last     = (idx_r == cnt_r - FILL_W'(1));
  assign ram_rd_addr = idx_r[AW-1:0];

  always_comb begin
    state_nxt  = state_r;
    cnt_nxt    = cnt_r;
    idx_nxt    = idx_r;
    drop_nxt   = drop_r;
    vld_nxt    = vld_r && !out_ready;
    byte_nxt   = byte_r;
    last_nxt   = last_r;
    ovf_nxt    = ovf_r;
    q_pop      = 1'b0;
    ram_rd_en  = 1'b0;
    drain_done = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (!q_empty) begin
          if (q_cmd.kind == CMD_SINGLE) begin
            if (slot_free) begin
              q_pop    = 1'b1;
              vld_nxt  = 1'b1;
              byte_nxt = q_cmd.data;
              last_nxt = 1'b1;
              ovf_nxt  = 1'b0;
            end
          end else begin
            q_pop     = 1'b1;
            cnt_nxt   = q_cmd.cnt;
            drop_nxt  = q_cmd.drop;
            idx_nxt   = '0;
            state_nxt = ST_READ;
          end
        end
      end
      ST_READ: begin
        if (slot_free) begin
          ram_rd_en = 1'b1;
          state_nxt = ST_LOAD;
        end
      end
      ST_LOAD: begin
        vld_nxt  = 1'b1;
        byte_nxt = ram_rd_data;
        last_nxt = is_last;
        ovf_nxt  = drop_r;
        if (is_last) begin
          drain_done = 1'b1;
          state_nxt  = ST_IDLE;
        end else begin
          idx_nxt   = idx_r + FILL_W'(1);
          state_nxt = ST_READ;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      vld_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      vld_r   <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r  <= cnt_nxt;
    idx_r  <= idx_nxt;
    drop_r <= drop_nxt;
    byte_r <= byte_nxt;
    last_r <= last_nxt;
    ovf_r  <= ovf_nxt;
  end

  assign out_valid          = vld_r;
  assign out_frame_byte     = byte_r;
  assign out_frame_last     = last_r;
  assign out_frame_overflow = ovf_r;

endmodule

FILE: tb/sv/uart_rx_idle_timeout_framer_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uart_rx_idle_timeout_framer_unit_tb
// Self-checking bench for the UART receive idle-timeout frame assembler.
// Bytes and ticks go in over a bursty valid/ready channel. A behavioral
// framer model inside the bench predicts every delivered frame byte, and
// each accepted output byte is checked in order. The run covers both modes,
// short and moved timeouts, a full store with dropped bytes,
// and long output stalls.
// ----------------------------------------------------------------------------
module uart_rx_idle_timeout_framer_unit_tb;
  import urx_ito_pkg::*;

  localparam int DEPTH       = DEF_BUF_DEPTH;
  localparam int SETTLE_CYC  = 16;
  localparam int HOLD_CYC    = 400;
  localparam int STALL_LIMIT = 5000;
  localparam int RANDOM_REQS = 60;
  localparam int MAX_REPORTS = 10;

  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic              last;
    logic              ovf;
  } frame_beat_t;

  logic                  clk;
  logic                  rst_n       = 1'b0;
  logic                  cfg_wr_en   = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index   = REG_SINGLE_BYTE_MODE;
  logic [CFG_DATA_W-1:0] cfg_wr_data = '0;
  logic                  in_valid    = 1'b0;
  logic                  in_ready;
  logic                  in_req_type = REQ_BYTE;
  logic [BYTE_W-1:0]     in_rx_byte  = '0;
  logic                  out_valid;
  logic                  out_ready   = 1'b0;
  logic [BYTE_W-1:0]     out_frame_byte;
  logic                  out_frame_last;
  logic                  out_frame_overflow;

  logic [BYTE_W-1:0] frm_store [DEPTH];
  int unsigned       frm_fill;
  logic [TMO_W-1:0]  frm_idle;
  bit                frm_armed;
  bit                frm_dropped;
  bit                frm_single;
  logic [TMO_W-1:0]  frm_tmo;
  frame_beat_t       due_bytes [$];

  int  req_sent;
  int  byte_sent;
  int  tick_sent;
  int  beats_seen;
  int  ovf_frames;
  int  fail_cnt;
  int  burst_left;
  bit  gaps_on = 1'b1;
  bit  hold_off_req = 1'b0;

  uart_rx_idle_timeout_framer_unit #(
    .BUF_DEPTH(DEPTH)
  ) DUT (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_index         (cfg_index),
    .cfg_wr_data       (cfg_wr_data),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_req_type       (in_req_type),
    .in_rx_byte        (in_rx_byte),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_frame_byte    (out_frame_byte),
    .out_frame_last    (out_frame_last),
    .out_frame_overflow(out_frame_overflow)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic logic [BYTE_W-1:0] rand_byte();
    return BYTE_W'($urandom_range(0, 255));
  endfunction

  task automatic clear_frame();
    frm_fill    = 0;
    frm_idle    = '0;
    frm_armed   = 1'b0;
    frm_dropped = 1'b0;
  endtask

  task automatic absorb_request(input req_kind_t kind, input logic [BYTE_W-1:0] b);
    frame_beat_t beat;
    if (kind == REQ_BYTE) begin
      if (frm_single) begin
        beat = '{data: b, last: 1'b1, ovf: 1'b0};
        due_bytes.push_back(beat);
      end else begin
        if (frm_fill < DEPTH) begin
          frm_store[frm_fill] = b;
          frm_fill++;
        end else begin
          frm_dropped = 1'b1;
        end
        frm_idle  = '0;
        frm_armed = 1'b1;
      end
    end else if (frm_armed) begin
      frm_idle = frm_idle + TMO_W'(1);
      if (frm_idle == frm_tmo) begin
        for (int k = 0; k < frm_fill; k++) begin
          beat = '{data: frm_store[k], last: (k == frm_fill - 1), ovf: frm_dropped};
          due_bytes.push_back(beat);
        end
        if (frm_dropped) ovf_frames++;
        clear_frame();
      end
    end
  endtask

  task automatic send_req(input req_kind_t kind, input logic [BYTE_W-1:0] b);
    int gap;
    if (gaps_on) begin
      if (burst_left == 0) begin
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        if (gap > 0) begin
          in_valid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
        burst_left = $urandom_range(1, 16);
      end
      burst_left--;
    end
    in_valid    <= 1'b1;
    in_req_type <= kind;
    in_rx_byte  <= b;
    do @(posedge clk); while (in_ready !== 1'b1);
    absorb_request(kind, b);
    req_sent++;
    if (kind == REQ_BYTE) byte_sent++;
    else tick_sent++;
  endtask

  task automatic send_ticks(input int n);
    repeat (n) send_req(REQ_TICK, rand_byte());
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (due_bytes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  task automatic cfg_write(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] val);
    cfg_wr_en   <= 1'b1;
    cfg_index   <= idx;
    cfg_wr_data <= val;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    @(posedge clk);
    case (idx)
      REG_SINGLE_BYTE_MODE: frm_single = val[0];
      REG_FRAME_TIMEOUT:    frm_tmo    = val[TMO_W-1:0];
      default: ;
    endcase
  endtask

  task automatic test_default_timeout();
    send_req(REQ_TICK, 8'hFF);
    send_req(REQ_BYTE, 8'h81);
    send_ticks(9);
    send_req(REQ_BYTE, 8'h7E);
    send_ticks(10);
    wait_idle();
  endtask

  task automatic test_single_byte();
    cfg_write(REG_SINGLE_BYTE_MODE, CFG_DATA_W'(1));
    send_req(REQ_TICK, 8'h00);
    send_req(REQ_BYTE, 8'h00);
    send_req(REQ_BYTE, 8'hFF);
    send_req(REQ_BYTE, 8'hA5);
    send_req(REQ_BYTE, 8'h5A);
    wait_idle();
    cfg_write(REG_SINGLE_BYTE_MODE, CFG_DATA_W'(0));
  endtask

  task automatic test_min_timeout();
    cfg_write(REG_FRAME_TIMEOUT, CFG_DATA_W'(1));
    send_req(REQ_BYTE, 8'h00);
    send_req(REQ_BYTE, 8'hFF);
    send_req(REQ_TICK, 8'h00);
    send_req(REQ_BYTE, 8'h3C);
    send_req(REQ_TICK, 8'hFF);
    send_req(REQ_TICK, 8'h00);
    wait_idle();
  endtask

  task automatic test_pending_bypass();
    cfg_write(REG_FRAME_TIMEOUT, CFG_DATA_W'(6));
    send_req(REQ_BYTE, 8'h11);
    send_req(REQ_BYTE, 8'h22);
    send_ticks(3);
    wait_idle();
    cfg_write(REG_SINGLE_BYTE_MODE, CFG_DATA_W'(1));
    send_req(REQ_BYTE, 8'h33);
    send_ticks(1);
    wait_idle();
    cfg_write(REG_SINGLE_BYTE_MODE, CFG_DATA_W'(0));
    send_ticks(2);
    wait_idle();
  endtask

  task automatic test_timeout_moved();
    cfg_write(REG_FRAME_TIMEOUT, CFG_DATA_W'(20));
    send_req(REQ_BYTE, 8'h96);
    send_ticks(12);
    wait_idle();
    cfg_write(REG_FRAME_TIMEOUT, CFG_DATA_W'(15));
    send_ticks(3);
    wait_idle();
  endtask

  task automatic test_store_full();
    cfg_write(REG_FRAME_TIMEOUT, CFG_DATA_W'(2));
    repeat (DEPTH) send_req(REQ_BYTE, rand_byte());
    send_ticks(2);
    repeat (DEPTH + 6) send_req(REQ_BYTE, rand_byte());
    send_ticks(2);
    wait_idle();
  endtask

  task automatic test_backpressure();
    cfg_write(REG_SINGLE_BYTE_MODE, CFG_DATA_W'(1));
    hold_off_req = 1'b1;
    repeat (24) send_req(REQ_BYTE, rand_byte());
    wait_idle();
    cfg_write(REG_SINGLE_BYTE_MODE, CFG_DATA_W'(0));
    cfg_write(REG_FRAME_TIMEOUT, CFG_DATA_W'(1));
    hold_off_req = 1'b1;
    repeat (40) send_req(REQ_BYTE, rand_byte());
    send_ticks(1);
    repeat (6) send_req(REQ_BYTE, rand_byte());
    send_ticks(1);
    wait_idle();
  endtask

  task automatic test_random_traffic();
    int start;
    int tmo;
    int nb;
    start = req_sent;
    while (req_sent - start < RANDOM_REQS) begin
      wait_idle();
      case ($urandom_range(0, 4))
        0:       tmo = 1;
        1:       tmo = $urandom_range(2, 4);
        default: tmo = $urandom_range(2, 9);
      endcase
      cfg_write(REG_FRAME_TIMEOUT, CFG_DATA_W'(tmo));
      cfg_write(REG_SINGLE_BYTE_MODE, CFG_DATA_W'($urandom_range(0, 4) == 0));
      repeat (4) begin
        if ($urandom_range(0, 4) == 0) begin
          repeat ($urandom_range(1, 4))
            send_req(req_kind_t'($urandom_range(0, 1)), rand_byte());
        end else begin
          nb = ($urandom_range(0, 24) == 0) ? $urandom_range(60, 70) : $urandom_range(1, 5);
          repeat (nb) begin
            send_req(REQ_BYTE, rand_byte());
            if ($urandom_range(0, 5) == 0) send_ticks(1);
          end
          send_ticks(tmo + $urandom_range(0, 2));
        end
      end
    end
    wait_idle();
  endtask

  initial begin : stimulus
    frm_single = 1'b0;
    frm_tmo    = TMO_RESET;
    clear_frame();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_default_timeout();
    test_single_byte();
    test_min_timeout();
    test_pending_bypass();
    test_timeout_moved();
    test_store_full();
    test_backpressure();
    test_random_traffic();
    wait_idle();
    $display("Run covered %0d requests (%0d bytes, %0d ticks), %0d frame bytes checked,",
             req_sent, byte_sent, tick_sent, beats_seen);
    $display("%0d overflowed frames, both modes, short and lowered timeouts, long stalls.",
             ovf_frames);
    if (fail_cnt == 0 && due_bytes.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin : receiver
    int mode;
    int mode_left;
    int hold_left;
    int phase;
    mode      = 0;
    mode_left = 0;
    hold_left = 0;
    phase     = 0;
    forever begin
      @(posedge clk);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        hold_left    = HOLD_CYC;
      end
      if (mode_left == 0) begin
        mode      = $urandom_range(0, 2);
        mode_left = $urandom_range(32, 256);
      end
      mode_left--;
      phase++;
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        case (mode)
          0:       out_ready <= 1'b1;
          1:       out_ready <= ($urandom_range(0, 99) >= 30);
          default: out_ready <= ((phase % 7) < 4);
        endcase
      end
    end
  end

  always @(posedge clk) begin
    frame_beat_t want;
    if (rst_n && out_valid === 1'b1 && out_ready) begin
      beats_seen++;
      if (due_bytes.size() == 0) begin
        fail_cnt++;
        if (fail_cnt <= MAX_REPORTS)
          $display("unexpected frame byte: byte %h last %b ovf %b",
                   out_frame_byte, out_frame_last, out_frame_overflow);
      end else begin
        want = due_bytes.pop_front();
        if (out_frame_byte !== want.data || out_frame_last !== want.last ||
            out_frame_overflow !== want.ovf) begin
          fail_cnt++;
          if (fail_cnt <= MAX_REPORTS)
            $display("frame byte %0d mismatch: exp byte %h last %b ovf %b, %s %h %s %b %s %b",
                     beats_seen, want.data, want.last, want.ovf,
                     "got byte", out_frame_byte, "last", out_frame_last,
                     "ovf", out_frame_overflow);
        end
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet = 0;
      else quiet++;
    end
    $display("no request or frame byte moved for %0d cycles", STALL_LIMIT);
    $display("*** FAILED ***");
    $finish;
  end

endmodule
